### src/fbr_pkg.sv
// Shared types and constants for the fieldbus frame receiver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fbr_pkg;

  // Start delimiters
  localparam logic [7:0] DELIM_NO_DATA    = 8'h10;
  localparam logic [7:0] DELIM_VAR_LEN    = 8'h68;
  localparam logic [7:0] DELIM_FIXED_DATA = 8'hA2;
  localparam logic [7:0] DELIM_TOKEN      = 8'hDC;

  localparam logic [7:0] SAP_BIT        = 8'h80;
  localparam logic [6:0] BROADCAST_ADDR = 7'h7F;
  localparam logic [6:0] STATION_RESET  = 7'd126;

  // Byte positions within a telegram
  localparam int HDR_POS_PLAIN    = 1;
  localparam int HDR_POS_VAR      = 4;
  localparam int LEN_POS          = 1;
  localparam int DSAP_POS         = 7;
  localparam int SSAP_POS         = 8;
  localparam int NO_DATA_LAST_SUM = 3;
  localparam int NO_DATA_CHK_POS  = 4;
  localparam int FIXED_LAST_SUM   = 8;
  localparam int FIXED_CHK_POS    = 9;
  localparam int VAR_FIRST_SUM    = 4;
  localparam int VAR_SUM_OFFSET   = 3;
  localparam int VAR_CHK_OFFSET   = 4;

  // Expected byte counts and PDU lengths
  localparam int LEN_NO_DATA    = 6;
  localparam int LEN_FIXED_DATA = 11;
  localparam int LEN_TOKEN      = 3;
  localparam int VAR_OVERHEAD   = 6;

  localparam logic [7:0] PDU_NO_DATA    = 8'd3;
  localparam logic [7:0] PDU_FIXED_DATA = 8'd8;
  localparam logic [7:0] PDU_TOKEN      = 8'd2;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_EOF  = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED      = 3'd0,
    ST_BAD_DELIM     = 3'd1,
    ST_BAD_LENGTH    = 3'd2,
    ST_NOT_ADDRESSED = 3'd3,
    ST_BAD_CHECKSUM  = 3'd4,
    ST_TOKEN_IGNORED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_NO_DATA    = 2'd0,
    KIND_VAR_LEN    = 2'd1,
    KIND_FIXED_DATA = 2'd2,
    KIND_TOKEN      = 2'd3
  } frame_kind_t;

  // Collected header bytes and checksum state of the current telegram
  typedef struct packed {
    logic [7:0] start_delim;
    logic [7:0] length_byte;
    logic [7:0] dest_byte;
    logic [7:0] src_byte;
    logic [7:0] func_byte;
    logic [7:0] dsap_byte;
    logic [7:0] ssap_byte;
    logic [7:0] running_sum;
    logic [7:0] check_byte;
  } frame_hdr_t;

  typedef struct packed {
    status_t     status;
    frame_kind_t frame_kind;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic [7:0]  func_code;
    logic        has_sap;
    logic [7:0]  dest_sap;
    logic [7:0]  src_sap;
    logic [7:0]  pdu_length;
  } frame_res_t;

  // Control from the input stage to the collector
  typedef struct packed {
    logic       take_byte;
    logic       end_frame;
    logic [7:0] rx_byte;
  } collect_ctrl_t;

endpackage

`default_nettype wire

### src/fbr_req_if.sv
// Request channel of the frame receiver: received bytes and end-of-frame events.
// Depends on fbr_pkg.
`default_nettype none

interface fbr_req_if;
  import fbr_pkg::*;

  logic       valid;
  logic       ready;
  logic [0:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/fbr_res_if.sv
// Result channel of the frame receiver: status and decoded header per telegram.
// Depends on fbr_pkg.
`default_nettype none

interface fbr_res_if;
  import fbr_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  frame_kind_t frame_kind;
  logic [7:0]  dest_addr;
  logic [7:0]  src_addr;
  logic [7:0]  func_code;
  logic        has_sap;
  logic [7:0]  dest_sap;
  logic [7:0]  src_sap;
  logic [7:0]  pdu_length;

  modport source (
    output valid, output status, output frame_kind, output dest_addr, output src_addr,
    output func_code, output has_sap, output dest_sap, output src_sap, output pdu_length,
    input ready
  );
  modport sink (
    input valid, input status, input frame_kind, input dest_addr, input src_addr,
    input func_code, input has_sap, input dest_sap, input src_sap, input pdu_length,
    output ready
  );
endinterface

`default_nettype wire

### src/fbr_collect.sv
// Byte collector: counts telegram bytes, captures header bytes, accumulates checksum.
// Depends on fbr_pkg.
`default_nettype none

module fbr_collect #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fbr_pkg::collect_ctrl_t      ctrl,
  output fbr_pkg::frame_hdr_t              hdr,
  output logic [$clog2(BUFFER_BYTES)-1:0]  byte_count
);
  import fbr_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam int CMP_W = (CNT_W > 9 ? CNT_W : 9) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES - 1);

  frame_hdr_t       hdr_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [CMP_W-1:0] idx;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] hdr_pos;
  logic             is_var;
  logic [7:0]       b;

  always_comb begin
    hdr_next        = hdr;
    byte_count_next = byte_count;
    b               = ctrl.rx_byte;
    idx             = CMP_W'(byte_count);
    len_ext         = CMP_W'(hdr.length_byte);
    is_var          = (hdr.start_delim == DELIM_VAR_LEN);
    hdr_pos         = is_var ? CMP_W'(HDR_POS_VAR) : CMP_W'(HDR_POS_PLAIN);

    if (ctrl.end_frame) begin
      hdr_next        = '0;
      byte_count_next = '0;
    end else if (ctrl.take_byte) begin
      if (idx == '0) begin
        hdr_next.start_delim = b;
      end else begin
        if (idx == CMP_W'(LEN_POS))    hdr_next.length_byte = b;
        if (idx == hdr_pos)            hdr_next.dest_byte   = b;
        if (idx == hdr_pos + CMP_W'(1)) hdr_next.src_byte   = b;
        if (idx == hdr_pos + CMP_W'(2)) hdr_next.func_byte  = b;
        if (idx == CMP_W'(DSAP_POS))   hdr_next.dsap_byte   = b;
        if (idx == CMP_W'(SSAP_POS))   hdr_next.ssap_byte   = b;
        if (hdr.start_delim == DELIM_NO_DATA) begin
          if (idx <= CMP_W'(NO_DATA_LAST_SUM)) hdr_next.running_sum = hdr.running_sum + b;
          if (idx == CMP_W'(NO_DATA_CHK_POS))  hdr_next.check_byte  = b;
        end else if (hdr.start_delim == DELIM_FIXED_DATA) begin
          if (idx <= CMP_W'(FIXED_LAST_SUM)) hdr_next.running_sum = hdr.running_sum + b;
          if (idx == CMP_W'(FIXED_CHK_POS))  hdr_next.check_byte  = b;
        end else if (is_var) begin
          if (idx >= CMP_W'(VAR_FIRST_SUM) && idx <= len_ext + CMP_W'(VAR_SUM_OFFSET)) begin
            hdr_next.running_sum = hdr.running_sum + b;
          end
          if (idx == len_ext + CMP_W'(VAR_CHK_OFFSET)) hdr_next.check_byte = b;
        end
      end
      // saturate at the last buffer position
      if (byte_count != CNT_MAX) byte_count_next = byte_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr        <= '0;
      byte_count <= '0;
    end else begin
      hdr        <= hdr_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

### src/fbr_check.sv
// Frame checker: judges delimiter, length, destination and checksum of a collected telegram.
// Depends on fbr_pkg.
`default_nettype none

module fbr_check #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire fbr_pkg::frame_hdr_t               hdr,
  input  wire logic [$clog2(BUFFER_BYTES)-1:0]   byte_count,
  input  wire logic [6:0]                        station_address,
  output fbr_pkg::frame_res_t                    res,
  output logic                                   has_bytes
);
  import fbr_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam int CMP_W = (CNT_W > 9 ? CNT_W : 9) + 1;

  logic [CMP_W-1:0] need;
  logic [CMP_W-1:0] count_ext;
  logic             known;
  logic             data_frame;
  logic             addressed;

  assign has_bytes = (byte_count != '0);
  assign count_ext = CMP_W'(byte_count);

  assign addressed = (hdr.dest_byte == {1'b0, station_address}) ||
                     (hdr.dest_byte == {1'b1, station_address}) ||
                     (hdr.dest_byte == {1'b0, BROADCAST_ADDR}) ||
                     (hdr.dest_byte == {1'b1, BROADCAST_ADDR});

  always_comb begin
    res        = '0;
    res.status = ST_BAD_DELIM;
    need       = '0;
    known      = 1'b1;
    data_frame = 1'b1;

    unique case (hdr.start_delim)
      DELIM_NO_DATA: begin
        res.frame_kind = KIND_NO_DATA;
        res.pdu_length = PDU_NO_DATA;
        need           = CMP_W'(LEN_NO_DATA);
      end
      DELIM_VAR_LEN: begin
        res.frame_kind = KIND_VAR_LEN;
        res.pdu_length = hdr.length_byte;
        need           = CMP_W'(hdr.length_byte) + CMP_W'(VAR_OVERHEAD);
      end
      DELIM_FIXED_DATA: begin
        res.frame_kind = KIND_FIXED_DATA;
        res.pdu_length = PDU_FIXED_DATA;
        need           = CMP_W'(LEN_FIXED_DATA);
      end
      DELIM_TOKEN: begin
        res.frame_kind = KIND_TOKEN;
        res.pdu_length = PDU_TOKEN;
        need           = CMP_W'(LEN_TOKEN);
        data_frame     = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase

    if (known) begin
      res.dest_addr = hdr.dest_byte;
      res.src_addr  = hdr.src_byte;
      priority if (count_ext != need) res.status = ST_BAD_LENGTH;
      else if (!addressed)            res.status = ST_NOT_ADDRESSED;
      else if (!data_frame)           res.status = ST_TOKEN_IGNORED;
      else if (hdr.running_sum != hdr.check_byte) res.status = ST_BAD_CHECKSUM;
      else                            res.status = ST_ACCEPTED;
      if (data_frame) begin
        res.func_code = hdr.func_byte;
        if (((hdr.dest_byte & SAP_BIT) != '0) && ((hdr.src_byte & SAP_BIT) != '0)) begin
          res.has_sap  = 1'b1;
          res.dest_sap = hdr.dsap_byte;
          res.src_sap  = hdr.ssap_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/fieldbus_frame_receiver.sv
// Fieldbus frame receiver: input register, byte collector, frame checker, result register.
// One request transfer per cycle unless a stalled result holds the input stage; an end-of-frame
// result passes the input register and is then held in the result register until taken.
// A stalled result holds the input stage.
// Synchronous reset clears frame state, both stages and sets the station address to 126.
// Depends on fbr_pkg, fbr_req_if, fbr_res_if, fbr_collect and fbr_check.
`default_nettype none

module fieldbus_frame_receiver #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  fbr_req_if.sink         req,
  fbr_res_if.source       res
);
  import fbr_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_BYTES);

  logic             s1_valid;
  req_kind_t        s1_kind;
  logic [7:0]       s1_byte;
  logic             s1_go;
  logic [6:0]       station_address;
  collect_ctrl_t    ctrl;
  frame_hdr_t       hdr;
  logic [CNT_W-1:0] byte_count;
  frame_res_t       chk_res;
  logic             chk_has_bytes;
  logic             res_valid;
  frame_res_t       res_q;

  // advance the input stage unless a result is waiting and not yet taken
  assign s1_go     = s1_valid && !(res_valid && !res.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_RESET;
    end else if (cfg_we) begin
      station_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_kind <= req_kind_t'(req.req_type);
      s1_byte <= req.rx_byte;
    end
  end

  assign ctrl.take_byte = s1_go && (s1_kind == REQ_BYTE);
  assign ctrl.end_frame = s1_go && (s1_kind == REQ_EOF);
  assign ctrl.rx_byte   = s1_byte;

  fbr_collect #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_collect (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hdr        (hdr),
    .byte_count (byte_count)
  );

  fbr_check #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_check (
    .hdr             (hdr),
    .byte_count      (byte_count),
    .station_address (station_address),
    .res             (chk_res),
    .has_bytes       (chk_has_bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (ctrl.end_frame && chk_has_bytes) || (res_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.end_frame && chk_has_bytes) begin
      res_q <= chk_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.status     = res_q.status;
  assign res.frame_kind = res_q.frame_kind;
  assign res.dest_addr  = res_q.dest_addr;
  assign res.src_addr   = res_q.src_addr;
  assign res.func_code  = res_q.func_code;
  assign res.has_sap    = res_q.has_sap;
  assign res.dest_sap   = res_q.dest_sap;
  assign res.src_sap    = res_q.src_sap;
  assign res.pdu_length = res_q.pdu_length;

endmodule

`default_nettype wire

### sim/tb_fieldbus_frame_receiver.sv
// Testbench for fieldbus_frame_receiver: byte and end-of-frame transfers in, telegram results
// out, every result checked field by field against an in-bench predictor or a directed table row.
// Depends on fbr_pkg, fbr_req_if, fbr_res_if and the receiver RTL.
`timescale 1ns / 1ps

module tb_fieldbus_frame_receiver;
  import fbr_pkg::*;

  localparam int          BUF_BYTES    = 256;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          DIR_ROWS     = 28;
  localparam int          MAX_PRINTS   = 30;
  localparam logic [7:0]  END_DELIM    = 8'h16;

  typedef struct {
    req_kind_t  kind;
    logic [7:0] data;
    bit         typed;
    frame_res_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  fbr_req_if req_ch ();
  fbr_res_if res_ch ();

  fieldbus_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the station register and the telegram being collected
  logic [6:0]  own_addr;
  int unsigned rx_count;
  logic [7:0]  f_delim, f_len, f_dst, f_src, f_fc, f_dsap, f_ssap, f_sum, f_chk;

  frame_res_t  due_results[$];
  stim_row_t   dir_tab[DIR_ROWS];
  int unsigned sent_items      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cfg_writes      = 0;
  int unsigned send_idle_pct   = 34;
  int unsigned recv_idle_pct   = 69;
  bit          hold_go         = 1'b0;
  bit          hold_done       = 1'b0;
  int unsigned hold_left       = 0;

  function automatic void clear_frame_state();
    rx_count = 0;
    f_delim  = '0;
    f_len    = '0;
    f_dst    = '0;
    f_src    = '0;
    f_fc     = '0;
    f_dsap   = '0;
    f_ssap   = '0;
    f_sum    = '0;
    f_chk    = '0;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    int unsigned pos, hdr;
    pos = rx_count;
    hdr = (f_delim == DELIM_VAR_LEN) ? HDR_POS_VAR : HDR_POS_PLAIN;
    if (pos == 0) begin
      f_delim = b;
    end else begin
      if (pos == LEN_POS) f_len = b;
      if (pos == hdr) f_dst = b;
      if (pos == hdr + 1) f_src = b;
      if (pos == hdr + 2) f_fc = b;
      if (pos == DSAP_POS) f_dsap = b;
      if (pos == SSAP_POS) f_ssap = b;
      case (f_delim)
        DELIM_NO_DATA: begin
          if (pos <= NO_DATA_LAST_SUM) f_sum += b;
          if (pos == NO_DATA_CHK_POS) f_chk = b;
        end
        DELIM_FIXED_DATA: begin
          if (pos <= FIXED_LAST_SUM) f_sum += b;
          if (pos == FIXED_CHK_POS) f_chk = b;
        end
        DELIM_VAR_LEN: begin
          // sum range and check position follow the length byte, overlap or not
          if (pos >= VAR_FIRST_SUM && pos <= f_len + VAR_SUM_OFFSET) f_sum += b;
          if (pos == f_len + VAR_CHK_OFFSET) f_chk = b;
        end
        default: ;
      endcase
    end
    // saturate: later bytes keep landing on the last position
    if (rx_count < BUF_BYTES - 1) rx_count++;
  endfunction

  function automatic bit close_frame(output frame_res_t r);
    int unsigned need;
    bit          data_fr;
    logic [7:0]  own8;
    r       = '0;
    need    = 0;
    data_fr = 1'b1;
    own8    = {1'b0, own_addr};
    if (rx_count == 0) begin
      clear_frame_state();
      return 1'b0;
    end
    r.status     = ST_BAD_DELIM;
    r.frame_kind = KIND_NO_DATA;
    case (f_delim)
      DELIM_NO_DATA: begin
        r.frame_kind = KIND_NO_DATA;
        r.pdu_length = PDU_NO_DATA;
        need         = LEN_NO_DATA;
      end
      DELIM_VAR_LEN: begin
        r.frame_kind = KIND_VAR_LEN;
        r.pdu_length = f_len;
        need         = f_len + VAR_OVERHEAD;
      end
      DELIM_FIXED_DATA: begin
        r.frame_kind = KIND_FIXED_DATA;
        r.pdu_length = PDU_FIXED_DATA;
        need         = LEN_FIXED_DATA;
      end
      DELIM_TOKEN: begin
        r.frame_kind = KIND_TOKEN;
        r.pdu_length = PDU_TOKEN;
        need         = LEN_TOKEN;
        data_fr      = 1'b0;
      end
      default: ;
    endcase
    if (need != 0) begin
      r.dest_addr = f_dst;
      r.src_addr  = f_src;
      if (rx_count != need) begin
        r.status = ST_BAD_LENGTH;
      end else if (!(f_dst == own8 || f_dst == (own8 | SAP_BIT) ||
                     f_dst == {1'b0, BROADCAST_ADDR} || f_dst == {1'b1, BROADCAST_ADDR})) begin
        r.status = ST_NOT_ADDRESSED;
      end else if (!data_fr) begin
        r.status = ST_TOKEN_IGNORED;
      end else if (f_sum != f_chk) begin
        r.status = ST_BAD_CHECKSUM;
      end else begin
        r.status = ST_ACCEPTED;
      end
      if (data_fr) begin
        r.func_code = f_fc;
        if (f_dst[7] && f_src[7]) begin
          r.has_sap  = 1'b1;
          r.dest_sap = f_dsap;
          r.src_sap  = f_ssap;
        end
      end
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    frame_res_t want;
    results_checked++;
    if (due_results.size() == 0) begin
      log_mismatch("result with none pending", res_ch.status, '0);
      return;
    end
    want = due_results.pop_front();
    if (res_ch.status !== want.status) log_mismatch("status", res_ch.status, want.status);
    if (res_ch.frame_kind !== want.frame_kind)
      log_mismatch("frame_kind", res_ch.frame_kind, want.frame_kind);
    if (res_ch.dest_addr !== want.dest_addr)
      log_mismatch("dest_addr", res_ch.dest_addr, want.dest_addr);
    if (res_ch.src_addr !== want.src_addr)
      log_mismatch("src_addr", res_ch.src_addr, want.src_addr);
    if (res_ch.func_code !== want.func_code)
      log_mismatch("func_code", res_ch.func_code, want.func_code);
    if (res_ch.has_sap !== want.has_sap) log_mismatch("has_sap", res_ch.has_sap, want.has_sap);
    if (res_ch.dest_sap !== want.dest_sap)
      log_mismatch("dest_sap", res_ch.dest_sap, want.dest_sap);
    if (res_ch.src_sap !== want.src_sap) log_mismatch("src_sap", res_ch.src_sap, want.src_sap);
    if (res_ch.pdu_length !== want.pdu_length)
      log_mismatch("pdu_length", res_ch.pdu_length, want.pdu_length);
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready) check_result();
  end

  // Result side: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One request transfer; the predictor advances once it is taken
  task automatic transfer(input req_kind_t kind, input logic [7:0] data,
                          input bit typed = 1'b0, input frame_res_t want = '0);
    frame_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_items++;
    if (kind == REQ_BYTE) begin
      absorb_byte(data);
    end else if (close_frame(r)) begin
      due_results.push_back(typed ? want : r);
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_station(input logic [6:0] addr);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_addr   = addr;
    cfg_writes++;
  endtask

  // Build one telegram, mostly well formed, sometimes damaged, then close it.
  // A non-negative var_len forces a clean variable-length telegram of that length.
  task automatic send_random_frame(input int var_len);
    logic [7:0] fr[$];
    logic [7:0] dst, cks;
    int         kind_sel, n, first;
    kind_sel = (var_len >= 0) ? 30 : $urandom_range(99);
    first    = 1;
    cks      = 8'h00;
    case ($urandom_range(4))
      0:       dst = {1'b0, own_addr};
      1:       dst = {1'b1, own_addr};
      2:       dst = {1'b0, BROADCAST_ADDR};
      3:       dst = {1'b1, BROADCAST_ADDR};
      default: dst = 8'($urandom_range(255));
    endcase
    if (kind_sel < 20) begin
      fr = '{DELIM_NO_DATA, dst, 8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (kind_sel < 45) begin
      if (var_len >= 0) n = var_len;
      else n = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 24);
      fr    = '{DELIM_VAR_LEN, 8'(n), 8'(n), DELIM_VAR_LEN};
      first = VAR_FIRST_SUM;
      for (int i = 4; i < n + 4; i++) fr.push_back((i == 4) ? dst : 8'($urandom_range(255)));
    end else if (kind_sel < 65) begin
      fr = '{DELIM_FIXED_DATA, dst};
      repeat (7) fr.push_back(8'($urandom_range(255)));
    end else if (kind_sel < 78) begin
      fr = '{DELIM_TOKEN, dst, 8'($urandom_range(255))};
    end else begin
      fr.delete();
      n  = $urandom_range(1, 12);
      repeat (n) fr.push_back(8'($urandom_range(255)));
      // let some noise open like a real telegram
      case ($urandom_range(5))
        0:       fr[0] = DELIM_NO_DATA;
        1:       fr[0] = DELIM_VAR_LEN;
        2:       fr[0] = DELIM_FIXED_DATA;
        3:       fr[0] = DELIM_TOKEN;
        default: ;
      endcase
    end
    if (kind_sel < 65) begin
      for (int i = first; i < fr.size(); i++) cks += fr[i];
      fr.push_back(cks);
      fr.push_back(END_DELIM);
    end
    if (kind_sel < 78 && var_len < 0) begin
      case ($urandom_range(19))
        0, 1:    if (kind_sel < 65) fr[fr.size() - 2] ^= 8'($urandom_range(1, 255));
        2:       void'(fr.pop_back());
        3:       fr.push_back(8'($urandom_range(255)));
        4:       fr[fr.size() - 1] = 8'($urandom_range(255));
        default: ;
      endcase
    end
    foreach (fr[i]) transfer(REQ_BYTE, fr[i]);
    transfer(REQ_EOF, 8'($urandom_range(255)));
    // an extra end of frame on an empty buffer must stay silent
    if ($urandom_range(15) == 0) transfer(REQ_EOF, 8'($urandom_range(255)));
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph, goal;
    logic [6:0]  ph_addr[6];
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_BYTE;
    req_ch.rx_byte  = '0;
    own_addr        = STATION_RESET;
    clear_frame_state();
    dir_tab = '{
      '{REQ_EOF,  8'h00, 1'b0, '0},
      '{REQ_BYTE, 8'hDC, 1'b0, '0},
      '{REQ_BYTE, 8'h7F, 1'b0, '0},
      '{REQ_BYTE, 8'h02, 1'b0, '0},
      '{REQ_EOF,  8'h00, 1'b1,
        '{ST_TOKEN_IGNORED, KIND_TOKEN, 8'h7F, 8'h02, 8'h00, 1'b0, 8'h00, 8'h00, PDU_TOKEN}},
      '{REQ_BYTE, 8'hFF, 1'b0, '0},
      '{REQ_EOF,  8'hFF, 1'b1,
        '{ST_BAD_DELIM, KIND_NO_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{REQ_BYTE, 8'h10, 1'b0, '0},
      '{REQ_EOF,  8'h00, 1'b1,
        '{ST_BAD_LENGTH, KIND_NO_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, PDU_NO_DATA}},
      '{REQ_BYTE, 8'hA2, 1'b0, '0},
      '{REQ_BYTE, 8'hFE, 1'b0, '0},
      '{REQ_BYTE, 8'h82, 1'b0, '0},
      '{REQ_BYTE, 8'h6C, 1'b0, '0},
      '{REQ_BYTE, 8'h00, 1'b0, '0},
      '{REQ_BYTE, 8'hFF, 1'b0, '0},
      '{REQ_BYTE, 8'h55, 1'b0, '0},
      '{REQ_BYTE, 8'hAA, 1'b0, '0},
      '{REQ_BYTE, 8'h01, 1'b0, '0},
      '{REQ_BYTE, 8'hEB, 1'b0, '0},
      '{REQ_BYTE, 8'h16, 1'b0, '0},
      '{REQ_EOF,  8'h00, 1'b0, '0},
      '{REQ_BYTE, 8'h68, 1'b0, '0},
      '{REQ_BYTE, 8'h00, 1'b0, '0},
      '{REQ_BYTE, 8'h00, 1'b0, '0},
      '{REQ_BYTE, 8'h68, 1'b0, '0},
      '{REQ_BYTE, 8'h7F, 1'b0, '0},
      '{REQ_BYTE, 8'h16, 1'b0, '0},
      '{REQ_EOF,  8'h00, 1'b0, '0}
    };
    ph_addr = '{7'd1, 7'd127, 7'd0, 7'($urandom_range(1, 126)), STATION_RESET,
                7'($urandom_range(1, 126))};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_station(STATION_RESET);

    foreach (dir_tab[i]) transfer(dir_tab[i].kind, dir_tab[i].data, dir_tab[i].typed,
                                  dir_tab[i].want);

    for (ph = 0; ph < 6; ph++) begin
      set_station(ph_addr[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        // hold the result side off while short telegrams keep coming
        hold_go <= 1'b1;
        repeat (30) begin
          transfer(REQ_BYTE, 8'($urandom_range(255)));
          transfer(REQ_EOF, 8'($urandom_range(255)));
        end
      end
      if (ph == 1) send_random_frame(249 + $urandom_range(1));
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) send_random_frame(-1);
    end

    settle();
    if (due_results.size() != 0) log_mismatch("results never delivered", due_results.size(), 0);
    $display("covered %0d request transfers and %0d telegram results under %0d station settings",
             sent_items, results_checked, cfg_writes);
    $display("idle mixes 34/69, 69/34 and none, one long result hold-off, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/fbr_pkg.sv
src/fbr_req_if.sv
src/fbr_res_if.sv
src/fbr_collect.sv
src/fbr_check.sv
src/fieldbus_frame_receiver.sv
sim/tb_fieldbus_frame_receiver.sv
